// ===== src/tddq_pkg.sv =====
`default_nettype none

package tddq_pkg;

    // Command store geometry
    localparam int QUEUE_DEPTH = 8;
    localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Item queue between front and back
    localparam int FIFO_DEPTH  = 2;
    localparam int FPTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FCNT_W      = $clog2(FIFO_DEPTH + 1);

    // Heading geometry in degrees
    localparam logic [8:0] QUAD1_DEG = 9'd90;
    localparam logic [8:0] QUAD2_DEG = 9'd180;
    localparam logic [8:0] QUAD3_DEG = 9'd270;
    localparam logic [8:0] DIR_LIMIT = 9'd360;
    localparam logic [8:0] DIR_MAX   = DIR_LIMIT - 9'd1;

    // Division by 90 as multiply by floor(2^16 / 90) and one correction step
    localparam int          RECIP_SHIFT = 16;
    localparam logic [9:0]  RECIP_90    = 10'((1 << RECIP_SHIFT) / 90);

    // Mode codes on the input channel
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_QUEUE = 2'd1;
    localparam logic [1:0] MODE_GO    = 2'd2;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_QUEUE,
        OP_GO,
        OP_NONE
    } op_t;

    typedef struct packed {
        logic [8:0]  direction;
        logic [31:0] duration_ms;
        logic [7:0]  speed;
    } cmd_entry_t;

    localparam int CMD_W = $bits(cmd_entry_t);

    typedef struct packed {
        op_t        op;
        cmd_entry_t cmd;
    } item_t;

endpackage

`default_nettype wire

// ===== src/tddq_if.sv =====
`default_nettype none

interface tddq_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [8:0]  direction;
    logic [31:0] duration_ms;
    logic [7:0]  speed;

    modport source (
        output valid, mode, direction, duration_ms, speed,
        input  ready
    );
    modport sink (
        input  valid, mode, direction, duration_ms, speed,
        output ready
    );
endinterface

interface tddq_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  left_forward;
    logic [7:0]  left_reverse;
    logic [7:0]  right_forward;
    logic [7:0]  right_reverse;
    logic        motor_enable;
    logic        accepted;
    logic        idle;

    modport source (
        output valid, left_forward, left_reverse, right_forward, right_reverse,
               motor_enable, accepted, idle,
        input  ready
    );
    modport sink (
        input  valid, left_forward, left_reverse, right_forward, right_reverse,
               motor_enable, accepted, idle,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/tddq_ram.sv =====
`default_nettype none

module tddq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/tddq_front.sv =====
`default_nettype none

module tddq_front
    import tddq_pkg::*;
(
    tddq_in_if.sink     cmd,
    output logic        push_valid,
    output item_t       push_item,
    input  wire logic   push_ready
);

    op_t        op;
    logic [8:0] dir_sat;

    // Decode the mode into an operation
    always_comb
    begin
        unique case (cmd.mode)
            MODE_TICK:  op = OP_TICK;
            MODE_QUEUE: op = OP_QUEUE;
            MODE_GO:    op = OP_GO;
            default:    op = OP_NONE;
        endcase
    end

    // Saturate the heading
    assign dir_sat = (cmd.direction > DIR_MAX) ? DIR_MAX : cmd.direction;

    assign push_item.op              = op;
    assign push_item.cmd.direction   = dir_sat;
    assign push_item.cmd.duration_ms = cmd.duration_ms;
    assign push_item.cmd.speed       = cmd.speed;

    // Accept a transaction whenever the item queue has room
    assign push_valid = cmd.valid;
    assign cmd.ready  = push_ready;

endmodule

`default_nettype wire

// ===== src/tddq_fifo.sv =====
`default_nettype none

module tddq_fifo
    import tddq_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push_valid,
    input  wire item_t  push_item,
    output logic        push_ready,
    output logic        pop_valid,
    output item_t       pop_item,
    input  wire logic   pop_ready
);

    item_t              slots_reg [FIFO_DEPTH];
    logic [FPTR_W-1:0]  wr_ptr_reg;
    logic [FPTR_W-1:0]  rd_ptr_reg;
    logic [FCNT_W-1:0]  count_reg;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != FCNT_W'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    function automatic logic [FPTR_W-1:0] ptr_inc(input logic [FPTR_W-1:0] p);
        ptr_inc = (p == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : p + FPTR_W'(1);
    endfunction

    // Store pushed items
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + FCNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - FCNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/tddq_back.sv =====
`default_nettype none

module tddq_back
    import tddq_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   pop_valid,
    input  wire item_t  pop_item,
    output logic        pop_ready,
    tddq_out_if.source  rsp
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RECIP,
        ST_FIX,
        ST_EMIT,
        ST_HOLD
    } state_t;

    state_t             state_reg,   state_next;
    logic [31:0]        rem_reg,     rem_next;
    logic               idle_reg,    idle_next;
    logic [QIDX_W-1:0]  head_reg,    head_next;
    logic [QCNT_W-1:0]  count_reg,   count_next;
    logic signed [8:0]  left_reg,    left_next;
    logic signed [8:0]  right_reg,   right_next;
    logic               en_reg,      en_next;
    logic               acc_reg,     acc_next;
    logic [7:0]         speed_reg,   speed_next;
    logic [1:0]         quad_reg,    quad_next;
    logic [15:0]        prod_reg,    prod_next;
    logic [9:0]         qest_reg,    qest_next;
    logic               valid_reg,   valid_next;
    logic [7:0]         lf_reg,      lf_next;
    logic [7:0]         lr_reg,      lr_next;
    logic [7:0]         rf_reg,      rf_next;
    logic [7:0]         rr_reg,      rr_next;
    logic               oen_reg,     oen_next;
    logic               oacc_reg,    oacc_next;
    logic               oidle_reg,   oidle_next;

    logic               ram_we;
    logic               ram_re;
    logic [QIDX_W-1:0]  tail_idx;
    logic [QIDX_W-1:0]  head_inc;
    logic [CMD_W-1:0]   ram_rdata;
    cmd_entry_t         rd_cmd;
    cmd_entry_t         start_cmd;
    logic               start_en;
    logic [1:0]         start_quad;
    logic [6:0]         start_off;
    logic [15:0]        start_mul;
    logic [31:0]        rem_dec;
    logic               has_entry;
    logic               store_full;
    logic [QIDX_W:0]    tail_sum;
    logic [25:0]        recip_prod;
    logic [16:0]        qx90;
    logic [16:0]        div_rem;
    logic [9:0]         quot;
    logic signed [9:0]  s_ext;
    logic signed [9:0]  q_ext;
    logic signed [9:0]  mix_left;
    logic signed [9:0]  mix_right;
    logic signed [8:0]  left_neg;
    logic signed [8:0]  right_neg;

    // Command store
    tddq_ram #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_idx),
        .wdata (pop_item.cmd),
        .re    (ram_re),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    assign rd_cmd = cmd_entry_t'(ram_rdata);

    // Ring arithmetic on the command store
    assign tail_sum   = (QIDX_W+1)'(head_reg) + (QIDX_W+1)'(count_reg);
    assign tail_idx   = (tail_sum >= (QIDX_W+1)'(QUEUE_DEPTH))
                        ? QIDX_W'(tail_sum - (QIDX_W+1)'(QUEUE_DEPTH))
                        : QIDX_W'(tail_sum);
    assign head_inc   = (head_reg == QIDX_W'(QUEUE_DEPTH - 1))
                        ? '0 : head_reg + QIDX_W'(1);
    assign has_entry  = (count_reg != '0);
    assign store_full = (count_reg == QCNT_W'(QUEUE_DEPTH));

    // Count the running command down, floor at zero
    assign rem_dec = (rem_reg != 32'd0) ? rem_reg - 32'd1 : 32'd0;

    // Select the command being started: store head or a go transaction
    assign start_cmd = (state_reg == ST_LOAD) ? rd_cmd : pop_item.cmd;

    // Find the quadrant and the offset within it
    always_comb
    begin
        priority if (start_cmd.direction < QUAD1_DEG)
        begin
            start_quad = 2'd0;
            start_off  = 7'(start_cmd.direction);
        end
        else if (start_cmd.direction < QUAD2_DEG)
        begin
            start_quad = 2'd1;
            start_off  = 7'(start_cmd.direction - QUAD1_DEG);
        end
        else if (start_cmd.direction < QUAD3_DEG)
        begin
            start_quad = 2'd2;
            start_off  = 7'(start_cmd.direction - QUAD2_DEG);
        end
        else
        begin
            start_quad = 2'd3;
            start_off  = 7'(start_cmd.direction - QUAD3_DEG);
        end
    end

    // speed * offset, at most 22695; doubled into the product register
    assign start_mul = 16'(start_off) * 16'(start_cmd.speed);

    // Quotient estimate and correction for division by 90
    assign recip_prod = 26'(prod_reg) * 26'(RECIP_90);
    assign qx90       = 17'(qest_reg) * 17'(QUAD1_DEG);
    assign div_rem    = 17'(prod_reg) - qx90;
    assign quot       = (div_rem >= 17'(QUAD1_DEG)) ? qest_reg + 10'd1 : qest_reg;

    // Blend the two wheel speeds across the quadrant
    assign s_ext = signed'({2'b00, speed_reg});
    assign q_ext = signed'(quot);

    always_comb
    begin
        unique case (quad_reg)
            2'd0:
            begin
                mix_left  = s_ext;
                mix_right = s_ext - q_ext;
            end
            2'd1:
            begin
                mix_left  = s_ext - q_ext;
                mix_right = -s_ext;
            end
            2'd2:
            begin
                mix_left  = -s_ext;
                mix_right = q_ext - s_ext;
            end
            default:
            begin
                mix_left  = q_ext - s_ext;
                mix_right = s_ext;
            end
        endcase
    end

    assign left_neg  = -left_reg;
    assign right_neg = -right_reg;

    // Sequence one item at a time
    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        idle_next  = idle_reg;
        head_next  = head_reg;
        count_next = count_reg;
        left_next  = left_reg;
        right_next = right_reg;
        en_next    = en_reg;
        acc_next   = acc_reg;
        speed_next = speed_reg;
        quad_next  = quad_reg;
        prod_next  = prod_reg;
        qest_next  = qest_reg;
        valid_next = valid_reg;
        lf_next    = lf_reg;
        lr_next    = lr_reg;
        rf_next    = rf_reg;
        rr_next    = rr_reg;
        oen_next   = oen_reg;
        oacc_next  = oacc_reg;
        oidle_next = oidle_reg;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        start_en   = 1'b0;
        pop_ready  = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    acc_next = 1'b0;
                    unique case (pop_item.op)
                        OP_TICK:
                        begin
                            state_next = ST_EMIT;
                            if (idle_reg)
                            begin
                                if (has_entry)
                                begin
                                    ram_re     = 1'b1;
                                    state_next = ST_LOAD;
                                end
                            end
                            else
                            begin
                                rem_next = rem_dec;
                                if (rem_dec == 32'd0)
                                begin
                                    if (has_entry)
                                    begin
                                        ram_re     = 1'b1;
                                        state_next = ST_LOAD;
                                    end
                                    else
                                    begin
                                        left_next  = '0;
                                        right_next = '0;
                                        en_next    = 1'b0;
                                        idle_next  = 1'b1;
                                    end
                                end
                            end
                        end
                        OP_QUEUE:
                        begin
                            if (!store_full)
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + QCNT_W'(1);
                                acc_next   = 1'b1;
                            end
                            state_next = ST_EMIT;
                        end
                        OP_GO:
                        begin
                            head_next  = '0;
                            count_next = '0;
                            acc_next   = 1'b1;
                            start_en   = 1'b1;
                        end
                        default:
                        begin
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_LOAD:
            begin
                head_next  = head_inc;
                count_next = count_reg - QCNT_W'(1);
                start_en   = 1'b1;
            end
            ST_RECIP:
            begin
                qest_next  = recip_prod[RECIP_SHIFT +: 10];
                state_next = ST_FIX;
            end
            ST_FIX:
            begin
                left_next  = mix_left[8:0];
                right_next = mix_right[8:0];
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                lf_next    = (left_reg > 0)  ? left_reg[7:0]  : 8'd0;
                lr_next    = (left_reg < 0)  ? left_neg[7:0]  : 8'd0;
                rf_next    = (right_reg > 0) ? right_reg[7:0] : 8'd0;
                rr_next    = (right_reg < 0) ? right_neg[7:0] : 8'd0;
                oen_next   = en_reg;
                oacc_next  = acc_reg;
                oidle_next = idle_reg;
                valid_next = 1'b1;
                state_next = ST_HOLD;
            end
            default:
            begin
                if (rsp.ready)
                begin
                    valid_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
        endcase

        // Start a command: load the timer and set up the mix
        if (start_en)
        begin
            rem_next   = start_cmd.duration_ms;
            idle_next  = 1'b0;
            speed_next = start_cmd.speed;
            quad_next  = start_quad;
            prod_next  = start_mul << 1;
            if (start_cmd.speed == 8'd0)
            begin
                left_next  = '0;
                right_next = '0;
                en_next    = 1'b0;
                state_next = ST_EMIT;
            end
            else
            begin
                en_next    = 1'b1;
                state_next = ST_RECIP;
            end
        end
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rem_reg   <= '0;
            idle_reg  <= 1'b1;
            head_reg  <= '0;
            count_reg <= '0;
            left_reg  <= '0;
            right_reg <= '0;
            en_reg    <= 1'b0;
            acc_reg   <= 1'b0;
            speed_reg <= '0;
            quad_reg  <= '0;
            prod_reg  <= '0;
            qest_reg  <= '0;
            valid_reg <= 1'b0;
            lf_reg    <= '0;
            lr_reg    <= '0;
            rf_reg    <= '0;
            rr_reg    <= '0;
            oen_reg   <= 1'b0;
            oacc_reg  <= 1'b0;
            oidle_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            rem_reg   <= rem_next;
            idle_reg  <= idle_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            left_reg  <= left_next;
            right_reg <= right_next;
            en_reg    <= en_next;
            acc_reg   <= acc_next;
            speed_reg <= speed_next;
            quad_reg  <= quad_next;
            prod_reg  <= prod_next;
            qest_reg  <= qest_next;
            valid_reg <= valid_next;
            lf_reg    <= lf_next;
            lr_reg    <= lr_next;
            rf_reg    <= rf_next;
            rr_reg    <= rr_next;
            oen_reg   <= oen_next;
            oacc_reg  <= oacc_next;
            oidle_reg <= oidle_next;
        end
    end

    assign rsp.valid         = valid_reg;
    assign rsp.left_forward  = lf_reg;
    assign rsp.left_reverse  = lr_reg;
    assign rsp.right_forward = rf_reg;
    assign rsp.right_reverse = rr_reg;
    assign rsp.motor_enable  = oen_reg;
    assign rsp.accepted      = oacc_reg;
    assign rsp.idle          = oidle_reg;

endmodule

`default_nettype wire

// ===== src/timed_differential_drive_queue.sv =====
// Each input transaction passes through the item queue to the back-end sequencer,
// which goes from idle to the emit state for ticks, queue writes, ignored modes and
// zero-speed starts; a start with nonzero speed goes through the reciprocal and fix
// states first, and a start from the store first passes the load state. The back-end
// sequencer works on one item at a time; a 2-entry item queue lets the input side
// keep accepting while a result waits. Reset is asynchronous, active low: idle, timer
// zero, store empty; command store contents are not cleared.
`default_nettype none

module timed_differential_drive_queue
    import tddq_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    tddq_in_if.sink     cmd,
    tddq_out_if.source  rsp
);

    logic   push_valid;
    logic   push_ready;
    item_t  push_item;
    logic   pop_valid;
    logic   pop_ready;
    item_t  pop_item;

    // Accept and classify transactions
    tddq_front u_front (
        .cmd        (cmd),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready)
    );

    // Decouple front from back
    tddq_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_ready  (pop_ready)
    );

    // Execute items: store, timer, mixing
    tddq_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_ready  (pop_ready),
        .rsp        (rsp)
    );

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import tddq_pkg::*;

    localparam logic [1:0] MODE_NONE   = OP_NONE;
    localparam int         Q1          = QUAD1_DEG;
    localparam int         Q2          = QUAD2_DEG;
    localparam int         Q3          = QUAD3_DEG;
    localparam int         PHASE_ITEMS = 610;
    localparam int         HOLD_CYCLES = 300;
    localparam int         TAIL_CYCLES = 20;
    localparam int         STALL_LIMIT = 3000;

    typedef struct packed {
        logic [7:0] left_forward;
        logic [7:0] left_reverse;
        logic [7:0] right_forward;
        logic [7:0] right_reverse;
        logic       motor_enable;
        logic       accepted;
        logic       idle;
    } duty_t;

    typedef struct {
        logic [1:0]  mode;
        logic [8:0]  direction;
        logic [31:0] duration_ms;
        logic [7:0]  speed;
        bit          typed;
        duty_t       duty;
    } steer_row_t;

    logic clk;
    logic rst_n;

    tddq_in_if  cmd_ch ();
    tddq_out_if rsp_ch ();

    timed_differential_drive_queue u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    // Drive model state
    logic [31:0] ms_left    = '0;
    bit          timer_idle = 1'b1;
    cmd_entry_t  cmd_fifo [QUEUE_DEPTH];
    int          head       = 0;
    int          pending    = 0;
    int          left_speed = 0;
    int          right_speed = 0;
    bit          motors_on  = 1'b0;

    duty_t expected_duties [$];
    int    mismatches   = 0;
    int    src_idle_pct = 0;
    int    snk_idle_pct = 0;
    bit    long_hold_req = 1'b0;

    // Directed transactions: corner headings, every mode, queue fill and overflow
    steer_row_t steer_rows [25] = '{
        '{MODE_TICK,  9'd0,   32'd0,          8'd0,   1'b1, '{8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b1}},
        '{MODE_NONE,  9'd511, 32'hFFFF_FFFF,  8'd255, 1'b1, '{8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b1}},
        '{MODE_GO,    9'd0,   32'd1,          8'd255, 1'b1, '{8'd255, 8'd0, 8'd255, 8'd0, 1'b1, 1'b1, 1'b0}},
        '{MODE_TICK,  9'd0,   32'd0,          8'd0,   1'b1, '{8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b1}},
        '{MODE_GO,    9'd90,  32'd0,          8'd255, 1'b1, '{8'd255, 8'd0, 8'd0, 8'd255, 1'b1, 1'b1, 1'b0}},
        '{MODE_TICK,  9'd0,   32'd0,          8'd0,   1'b1, '{8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b1}},
        '{MODE_GO,    9'd180, 32'd3,          8'd100, 1'b1, '{8'd0, 8'd100, 8'd0, 8'd100, 1'b1, 1'b1, 1'b0}},
        '{MODE_GO,    9'd270, 32'd2,          8'd1,   1'b1, '{8'd0, 8'd1, 8'd1, 8'd0, 1'b1, 1'b1, 1'b0}},
        '{MODE_GO,    9'd511, 32'd5,          8'd200, 1'b0, '0},
        '{MODE_GO,    9'd45,  32'd2,          8'd0,   1'b1, '{8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1, 1'b0}},
        '{MODE_QUEUE, 9'd45,  32'd0,          8'd255, 1'b0, '0},
        '{MODE_QUEUE, 9'd135, 32'd1,          8'd128, 1'b0, '0},
        '{MODE_QUEUE, 9'd225, 32'd2,          8'd77,  1'b0, '0},
        '{MODE_QUEUE, 9'd315, 32'd0,          8'd255, 1'b0, '0},
        '{MODE_QUEUE, 9'd360, 32'd1,          8'd9,   1'b0, '0},
        '{MODE_QUEUE, 9'd89,  32'd0,          8'd254, 1'b0, '0},
        '{MODE_QUEUE, 9'd359, 32'd3,          8'd170, 1'b0, '0},
        '{MODE_QUEUE, 9'd1,   32'hFFFF_FFFF,  8'd85,  1'b0, '0},
        '{MODE_QUEUE, 9'd10,  32'd1,          8'd1,   1'b0, '0},
        '{MODE_TICK,  9'd0,   32'd0,          8'd0,   1'b0, '0},
        '{MODE_TICK,  9'd0,   32'd0,          8'd0,   1'b0, '0},
        '{MODE_TICK,  9'd0,   32'd0,          8'd0,   1'b0, '0},
        '{MODE_TICK,  9'd0,   32'd0,          8'd0,   1'b0, '0},
        '{MODE_TICK,  9'd0,   32'd0,          8'd0,   1'b0, '0},
        '{MODE_GO,    9'd300, 32'd4,          8'd170, 1'b0, '0}
    };

    // Interpolate across one 90 degree quadrant, truncating toward zero
    function automatic int blend(int offset, int from, int to);
        return (offset * (to - from)) / 90 + from;
    endfunction

    function automatic void halt_motors();
        left_speed  = 0;
        right_speed = 0;
        motors_on   = 1'b0;
    endfunction

    function automatic void launch_drive(logic [8:0] dir, logic [31:0] dur, logic [7:0] spd);
        int s;
        int d;
        s = int'(spd);
        d = int'((dir > DIR_MAX) ? DIR_MAX : dir);
        if (s == 0) begin
            halt_motors();
        end
        else begin
            if (d < Q1) begin
                left_speed  = s;
                right_speed = blend(d, s, -s);
            end
            else if (d < Q2) begin
                left_speed  = blend(d - Q1, s, -s);
                right_speed = -s;
            end
            else if (d < Q3) begin
                left_speed  = -s;
                right_speed = blend(d - Q2, -s, s);
            end
            else begin
                left_speed  = blend(d - Q3, -s, s);
                right_speed = s;
            end
            motors_on = 1'b1;
        end
        ms_left    = dur;
        timer_idle = 1'b0;
    endfunction

    function automatic void start_from_fifo();
        cmd_entry_t c;
        c       = cmd_fifo[head];
        head    = (head + 1) % QUEUE_DEPTH;
        pending = pending - 1;
        launch_drive(c.direction, c.duration_ms, c.speed);
    endfunction

    // Count the running command down; start the next one or stop on expiry
    function automatic void advance_tick();
        if (timer_idle) begin
            if (pending > 0)
                start_from_fifo();
        end
        else begin
            if (ms_left > 0)
                ms_left = ms_left - 1;
            if (ms_left == 0) begin
                if (pending > 0) begin
                    start_from_fifo();
                end
                else begin
                    halt_motors();
                    timer_idle = 1'b1;
                end
            end
        end
    endfunction

    // Apply one transaction to the drive model and return the duties it shows
    function automatic duty_t step_drive_model(logic [1:0] mode, logic [8:0] dir,
                                               logic [31:0] dur, logic [7:0] spd);
        duty_t r;
        bit    took;
        took = 1'b0;
        case (mode)
            MODE_TICK: advance_tick();
            MODE_QUEUE: begin
                if (pending < QUEUE_DEPTH) begin
                    cmd_fifo[(head + pending) % QUEUE_DEPTH] =
                        '{direction: (dir > DIR_MAX) ? DIR_MAX : dir,
                          duration_ms: dur, speed: spd};
                    pending = pending + 1;
                    took    = 1'b1;
                end
            end
            MODE_GO: begin
                head    = 0;
                pending = 0;
                launch_drive(dir, dur, spd);
                took    = 1'b1;
            end
            default: ;
        endcase
        r.left_forward  = (left_speed > 0)  ? 8'(left_speed)   : 8'd0;
        r.left_reverse  = (left_speed < 0)  ? 8'(-left_speed)  : 8'd0;
        r.right_forward = (right_speed > 0) ? 8'(right_speed)  : 8'd0;
        r.right_reverse = (right_speed < 0) ? 8'(-right_speed) : 8'd0;
        r.motor_enable  = motors_on;
        r.accepted      = took;
        r.idle          = timer_idle;
        return r;
    endfunction

    task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Offer one transaction, wait for the handshake and record its expected duties
    task automatic offer_command(input logic [1:0] mode, input logic [8:0] dir,
                                 input logic [31:0] dur, input logic [7:0] spd,
                                 input bit typed, input duty_t typed_duty);
        duty_t predicted;
        while ($urandom_range(99) < src_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.mode        <= mode;
        cmd_ch.direction   <= dir;
        cmd_ch.duration_ms <= dur;
        cmd_ch.speed       <= spd;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        predicted = step_drive_model(mode, dir, dur, spd);
        expected_duties.push_back(typed ? typed_duty : predicted);
        @(negedge clk);
    endtask

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Sink side: random back-pressure, plus one long hold-off on request
    initial
    begin : sink_driver
        int  hold_left;
        bit  hold_used;
        hold_left    = 0;
        hold_used    = 1'b0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (long_hold_req && !hold_used) begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else begin
                rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin : duty_monitor
        duty_t seen;
        duty_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            seen = '{rsp_ch.left_forward, rsp_ch.left_reverse, rsp_ch.right_forward,
                     rsp_ch.right_reverse, rsp_ch.motor_enable, rsp_ch.accepted,
                     rsp_ch.idle};
            if (expected_duties.size() == 0) begin
                note_mismatch("result with nothing pending", 64'(seen), 64'd0);
            end
            else begin
                want = expected_duties.pop_front();
                if (seen.left_forward !== want.left_forward)
                    note_mismatch("left_forward", 64'(seen.left_forward),
                                  64'(want.left_forward));
                if (seen.left_reverse !== want.left_reverse)
                    note_mismatch("left_reverse", 64'(seen.left_reverse),
                                  64'(want.left_reverse));
                if (seen.right_forward !== want.right_forward)
                    note_mismatch("right_forward", 64'(seen.right_forward),
                                  64'(want.right_forward));
                if (seen.right_reverse !== want.right_reverse)
                    note_mismatch("right_reverse", 64'(seen.right_reverse),
                                  64'(want.right_reverse));
                if (seen.motor_enable !== want.motor_enable)
                    note_mismatch("motor_enable", 64'(seen.motor_enable),
                                  64'(want.motor_enable));
                if (seen.accepted !== want.accepted)
                    note_mismatch("accepted", 64'(seen.accepted), 64'(want.accepted));
                if (seen.idle !== want.idle)
                    note_mismatch("idle", 64'(seen.idle), 64'(want.idle));
            end
        end
    end

    // Abort when no transaction moves on either side for too long
    always @(posedge clk)
    begin : stall_watchdog
        int quiet;
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet = 0;
        end
        else begin
            quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", quiet);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Stimulus: reset, directed table, then three random phases
    initial
    begin : stimulus
        logic [1:0]  mode;
        logic [8:0]  dir;
        logic [31:0] dur;
        logic [7:0]  spd;
        int          roll;
        int          counted;
        bit          fill_regime;

        rst_n              = 1'b0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.mode        = MODE_TICK;
        cmd_ch.direction   = '0;
        cmd_ch.duration_ms = '0;
        cmd_ch.speed       = '0;
        fill_regime        = 1'b0;
        src_idle_pct       = 27;
        snk_idle_pct       = 55;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < $size(steer_rows); i++) begin
            offer_command(steer_rows[i].mode, steer_rows[i].direction,
                          steer_rows[i].duration_ms, steer_rows[i].speed,
                          steer_rows[i].typed, steer_rows[i].duty);
        end

        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 55 : 0;
            snk_idle_pct = (ph == 0) ? 55 : (ph == 1) ? 27 : 0;
            // fill the block up behind a long sink hold-off
            if (ph == 2)
                long_hold_req = 1'b1;
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                // every 40 items, pick at random between balanced traffic and bursts that fill the queue
                if (counted % 40 == 0)
                    fill_regime = ($urandom_range(2) == 0);
                roll = $urandom_range(99);
                if (fill_regime)
                    mode = (roll < 25) ? MODE_TICK : (roll < 85) ? MODE_QUEUE :
                           (roll < 90) ? MODE_GO : MODE_NONE;
                else
                    mode = (roll < 55) ? MODE_TICK : (roll < 80) ? MODE_QUEUE :
                           (roll < 93) ? MODE_GO : MODE_NONE;
                dir  = ($urandom_range(99) < 85) ? 9'($urandom_range(359)) :
                                                   9'($urandom_range(511, 360));
                roll = $urandom_range(99);
                dur  = (roll < 70) ? $urandom_range(4) :
                       (roll < 90) ? $urandom_range(20, 5) : $urandom();
                roll = $urandom_range(99);
                spd  = (roll < 10) ? 8'd0 : (roll < 20) ? 8'd255 : 8'($urandom_range(255));
                offer_command(mode, dir, dur, spd, 1'b0, '0);
                counted++;
            end
        end

        // Drain: wait for every expected result, then watch for strays
        cmd_ch.valid <= 1'b0;
        while (expected_duties.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
src/tddq_pkg.sv
src/tddq_if.sv
src/tddq_ram.sv
src/tddq_front.sv
src/tddq_fifo.sv
src/tddq_back.sv
src/timed_differential_drive_queue.sv
tb/sv/tb_top.sv
